// ----- sv/fdf_pkg.sv -----
// Shared constants and types for the four-digit decimal formatter.
package fdf_pkg;

    localparam int VALUE_W     = 32;
    localparam int BCD_DIGITS  = 10;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = BCD_DIGITS * DIGIT_W;
    localparam int SHOW_DIGITS = 4;
    localparam int NORM_SHIFTS = BCD_DIGITS - SHOW_DIGITS;
    localparam int CNT_W       = $clog2(VALUE_W);

    localparam logic [DIGIT_W-1:0] DIGIT_BLANK = 4'd10;

    typedef logic [DIGIT_W-1:0] digit_t;

    // Conversion result handed from the converter to the output stage.
    typedef struct packed {
        logic   valid;
        digit_t thousands;
        digit_t hundreds;
        digit_t tens;
        digit_t units;
    } conv_result_t;

endpackage

// ----- sv/four_digit_decimal_formatter_unit.sv -----
// Four-digit decimal formatter: 32-bit binary in, four blanked digit codes out.
// A request passes through the bit-serial double-dabble shift loop over all
// 32 input bits, then a step that shifts the BCD word up a digit at a time
// until the leading nonzero digit is in front or the units digit reaches the
// last shown place, then a hold state in which the result waits for the
// output register to take it. Values of 10000 or more keep their four leading
// digits (the value divided by ten, truncating, until it fits). Leading zeros
// read as code 10 (blank); the units digit always shows. The output register
// lets the next request start while a result still waits to be taken; a new
// request can be accepted the cycle after the result moves to the output
// register.
module four_digit_decimal_formatter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [3:0] units, [7:4] tens, [11:8] hundreds, [15:12] thousands
);

    fdf_pkg::conv_result_t result;
    logic                  conv_idle;
    logic                  load;
    logic                  m_tvalid_reg;
    logic [15:0]           m_tdata_reg, m_tdata_next;
    logic                  show_thous, show_hunds, show_tens;

    fdf_conv u_conv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (s_tvalid && s_tready),
        .value  (s_tdata),
        .take   (load),
        .idle   (conv_idle),
        .result (result)
    );

    assign s_tready = conv_idle;
    assign load     = result.valid && (!m_tvalid_reg || m_tready);

    assign show_thous = result.thousands != '0;
    assign show_hunds = show_thous || result.hundreds != '0;
    assign show_tens  = show_hunds || result.tens != '0;

    always_comb
    begin
        m_tdata_next = {show_thous ? result.thousands : fdf_pkg::DIGIT_BLANK,
                        show_hunds ? result.hundreds  : fdf_pkg::DIGIT_BLANK,
                        show_tens  ? result.tens      : fdf_pkg::DIGIT_BLANK,
                        result.units};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sv/fdf_conv.sv -----
// Bit-serial binary to BCD converter with leading-digit alignment.
module fdf_conv
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fdf_pkg::VALUE_W-1:0]   value,
    input  logic                          take,
    output logic                          idle,
    output fdf_pkg::conv_result_t         result
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_NORM = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [fdf_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [fdf_pkg::VALUE_W-1:0]     shift_reg, shift_next;
    logic [fdf_pkg::BCD_W-1:0]       bcd_reg, bcd_next;
    logic [fdf_pkg::BCD_W-1:0]       bcd_adj;
    logic                            top_nonzero;

    // Add 3 to every digit of 5 or more before the next doubling.
    always_comb
    begin
        for (int i = 0; i < fdf_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*fdf_pkg::DIGIT_W +: fdf_pkg::DIGIT_W] >= 4'd5)
            begin
                bcd_adj[i*fdf_pkg::DIGIT_W +: fdf_pkg::DIGIT_W] =
                    bcd_reg[i*fdf_pkg::DIGIT_W +: fdf_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[i*fdf_pkg::DIGIT_W +: fdf_pkg::DIGIT_W] =
                    bcd_reg[i*fdf_pkg::DIGIT_W +: fdf_pkg::DIGIT_W];
            end
        end
    end

    assign top_nonzero = bcd_reg[fdf_pkg::BCD_W-1 -: fdf_pkg::DIGIT_W] != '0;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    shift_next = value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next   = {bcd_adj[fdf_pkg::BCD_W-2:0], shift_reg[fdf_pkg::VALUE_W-1]};
                shift_next = {shift_reg[fdf_pkg::VALUE_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == fdf_pkg::CNT_W'(fdf_pkg::VALUE_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // Advance digits up until the leading one sits in the top place or NORM_SHIFTS shifts are done.
                if (top_nonzero || cnt_reg == fdf_pkg::CNT_W'(fdf_pkg::NORM_SHIFTS))
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    bcd_next = {bcd_reg[fdf_pkg::BCD_W-fdf_pkg::DIGIT_W-1:0],
                                {fdf_pkg::DIGIT_W{1'b0}}};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign idle             = state_reg == ST_IDLE;
    assign result.valid     = state_reg == ST_HOLD;
    assign result.thousands = bcd_reg[fdf_pkg::BCD_W-1 -: fdf_pkg::DIGIT_W];
    assign result.hundreds  = bcd_reg[fdf_pkg::BCD_W-1-fdf_pkg::DIGIT_W -: fdf_pkg::DIGIT_W];
    assign result.tens      = bcd_reg[fdf_pkg::BCD_W-1-2*fdf_pkg::DIGIT_W -: fdf_pkg::DIGIT_W];
    assign result.units     = bcd_reg[fdf_pkg::BCD_W-1-3*fdf_pkg::DIGIT_W -: fdf_pkg::DIGIT_W];

endmodule

// ----- sv/fdf_checker.sv -----
// Port-level checks for the four-digit decimal formatter, bound to the top level.
module fdf_assert
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

    // The converter is busy right after taking a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while conversion in progress");

    // Units digit is never blank.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= 4'd9)
    else $error("units digit out of range");

    // A blank digit has only blanks above it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:4] == fdf_pkg::DIGIT_BLANK
            |-> m_tdata[11:8] == fdf_pkg::DIGIT_BLANK)
    else $error("blank tens below shown hundreds");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11:8] == fdf_pkg::DIGIT_BLANK
            |-> m_tdata[15:12] == fdf_pkg::DIGIT_BLANK)
    else $error("blank hundreds below shown thousands");

endmodule

bind four_digit_decimal_formatter_unit fdf_assert u_fdf_assert (.*);
